@@ design/tod_pkg.sv @@
// Shared constants and register codes for the tanh overdrive sample shaper.
package tod_pkg;

	localparam int MODE_W  = 2;
	localparam int GAIN_W  = 22;
	localparam int RECIP_W = 17;
	localparam int TAB_W   = 17;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	localparam logic [TAB_W-1:0] Q16_ONE = 17'h10000;

	localparam logic [MODE_W-1:0] MODE_TANH   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CUBE   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BYPASS = 2'd2;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_GAIN  = 2'd1;
	localparam logic [1:0] REG_RECIP = 2'd2;

	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 22'd256;
	localparam logic [RECIP_W-1:0] RECIP_RESET = 17'd65536;

endpackage

@@ design/tod_if.sv @@
// Valid/ready stream interfaces for input and shaped output samples.
interface tod_in_if #(parameter int W = 16);
	logic         valid;
	logic         ready;
	logic [W-1:0] sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface tod_out_if #(parameter int W = 16);
	logic         valid;
	logic         ready;
	logic [W-1:0] sample_out;
	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

@@ design/tanh_overdrive_sample.sv @@
// Tanh soft-clipping sample shaper: APB registers and an eight-stage datapath.
// An accepted item passes through stages 1 to 8 in order; out_ch.valid is the stage 8 valid bit.
// Throughput: one item per cycle while out_ch.ready is high; every stage holds its own valid bit and a stage
// takes a new item whenever it is empty or its successor moves on.
// The tanh table is a constant ROM read through registered ports in stage 3.
// Reset clears all valid bits and sets mode 0, gain 1.0 and reciprocal 1.0; no sweep.
module tanh_overdrive_sample #(
	parameter int TANH_TABLE_DEPTH = 1024,
	parameter int SAMPLE_WIDTH     = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tod_pkg::APB_AW-1:0]  paddr,
	input  logic [tod_pkg::APB_DW-1:0]  pwdata,
	output logic [tod_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	tod_in_if.sink                      in_ch,
	tod_out_if.source                   out_ch
);
	import tod_pkg::*;

	localparam int W  = SAMPLE_WIDTH;
	localparam int F  = SAMPLE_WIDTH - 1;
	localparam int UW = SAMPLE_WIDTH + GAIN_W;
	localparam int AW = $clog2(TANH_TABLE_DEPTH + 1);
	localparam int SW = F + 11 + AW;
	localparam int PW = 2 * TAB_W + 1;
	localparam int QW = PW - (32 - F);

	localparam logic [PW-1:0] Q_RND   = PW'(1) << (31 - F);
	localparam logic [QW-1:0] MAX_NEG = QW'(1) << F;
	localparam logic [QW-1:0] MAX_POS = (QW'(1) << F) - QW'(1);

	// Configuration registers.
	logic [MODE_W-1:0]  mode_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [RECIP_W-1:0] recip_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_TANH;
			gain_q  <= GAIN_RESET;
			recip_q <= RECIP_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_MODE:  mode_q  <= pwdata[MODE_W-1:0];
				REG_GAIN:  gain_q  <= pwdata[GAIN_W-1:0];
				REG_RECIP: recip_q <= pwdata[RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MODE:  prdata = APB_DW'(mode_q);
			REG_GAIN:  prdata = APB_DW'(gain_q);
			REG_RECIP: prdata = APB_DW'(recip_q);
			default:   prdata = '0;
		endcase
	end

	// Stage valid bits and the ready chain.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8;

	assign rdy_s8 = !v_s8 || out_ch.ready;
	assign rdy_s7 = !v_s7 || rdy_s8;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ch.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_ch.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
			if (rdy_s8) v_s8 <= v_s7;
		end
	end

	// Datapath registers.
	logic [W-1:0]     raw_s1, raw_s2, raw_s3, raw_s4, raw_s5, raw_s6, raw_s7;
	logic [UW-1:0]    u_s2;
	logic [15:0]      f_s3;
	logic             sat_s3;
	logic [TAB_W-1:0] ta_s3, tb_s3;
	logic [TAB_W-1:0] y_s4, y_s5, y2_s5, y_s6;
	logic [QW-1:0]    q_s7;
	logic [W-1:0]     smp_s8;
	logic             neg_s8;

	// Stage 2 combinational: magnitude times gain.
	logic [W-1:0]  mag;
	assign mag = raw_s1[W-1] ? (~raw_s1 + W'(1)) : raw_s1;

	// Stage 3 combinational: table position.
	logic [SW-1:0] pos;
	logic [AW-1:0] idx;
	assign pos = SW'(u_s2[F+10:0]) * SW'(TANH_TABLE_DEPTH);
	assign idx = pos[F+11 +: AW];

	tod_tanh_rom #(
		.DEPTH (TANH_TABLE_DEPTH),
		.AW    (AW)
	) u_rom (
		.clk   (clk),
		.rd_en (rdy_s3 && v_s2),
		.addr  (idx),
		.lo    (ta_s3),
		.hi    (tb_s3)
	);

	// Stage 4 combinational: linear interpolation as ta + floor((tb - ta) * f / 2^16).
	logic signed [TAB_W:0]     diff;
	logic signed [TAB_W+17:0]  dprod;
	logic signed [TAB_W+1:0]   interp;
	assign diff   = signed'({1'b0, tb_s3}) - signed'({1'b0, ta_s3});
	assign dprod  = (TAB_W+18)'(diff) * signed'({{TAB_W+1{1'b0}}, f_s3});
	assign interp = signed'({2'b00, ta_s3}) + (TAB_W+2)'(dprod >>> 16);

	// Stages 5 to 7 combinational.
	logic [PW-1:0] sq, cube, scaled;
	assign sq     = PW'(y_s4) * PW'(y_s4) + PW'(32768);
	assign cube   = PW'(y2_s5) * PW'(y_s5) + PW'(32768);
	assign scaled = PW'(y_s6) * PW'(recip_q) + Q_RND;

	// Stage 8 combinational: clamp, sign and bypass.
	logic [QW-1:0] qc;
	logic [W-1:0]  shaped;
	always_comb begin
		if (raw_s7[W-1]) begin
			qc = (q_s7 > MAX_NEG) ? MAX_NEG : q_s7;
			shaped = W'(~qc + QW'(1));
		end else begin
			qc = (q_s7 > MAX_POS) ? MAX_POS : q_s7;
			shaped = W'(qc);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_ch.valid)
			raw_s1 <= in_ch.sample_in;
		if (rdy_s2 && v_s1) begin
			raw_s2 <= raw_s1;
			u_s2   <= UW'(mag) * UW'(gain_q);
		end
		if (rdy_s3 && v_s2) begin
			raw_s3 <= raw_s2;
			f_s3   <= pos[F-5 +: 16];
			sat_s3 <= |u_s2[UW-1:F+11];
		end
		if (rdy_s4 && v_s3) begin
			raw_s4 <= raw_s3;
			y_s4   <= sat_s3 ? Q16_ONE : TAB_W'(interp);
		end
		if (rdy_s5 && v_s4) begin
			raw_s5 <= raw_s4;
			y_s5   <= y_s4;
			y2_s5  <= sq[16 +: TAB_W];
		end
		if (rdy_s6 && v_s5) begin
			raw_s6 <= raw_s5;
			y_s6   <= (mode_q == MODE_CUBE) ? cube[16 +: TAB_W] : y_s5;
		end
		if (rdy_s7 && v_s6) begin
			raw_s7 <= raw_s6;
			q_s7   <= scaled[PW-1 : 32-F];
		end
		if (rdy_s8 && v_s7) begin
			smp_s8 <= (mode_q >= MODE_BYPASS) ? raw_s7 : shaped;
			neg_s8 <= raw_s7[W-1];
		end
	end

	assign out_ch.valid      = v_s8;
	assign out_ch.sample_out = smp_s8;

	// An empty output stage means the whole chain can take an item.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s8 |-> in_ch.ready)
		else $error("input not ready although output stage is empty");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> v_s1)
		else $error("accepted item did not reach stage 1");

	a_interp_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> y_s4 <= Q16_ONE)
		else $error("interpolated tanh exceeds one");

	a_sign_kept: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && (mode_q < MODE_BYPASS) && !neg_s8 |-> !smp_s8[W-1])
		else $error("shaped positive sample came out negative");

endmodule

@@ design/tod_tanh_rom.sv @@
// Constant tanh table built at elaboration, read at two neighboring entries per cycle while rd_en is high.
module tod_tanh_rom #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [AW-1:0]            addr,
	output logic [tod_pkg::TAB_W-1:0] lo,
	output logic [tod_pkg::TAB_W-1:0] hi
);
	import tod_pkg::*;

	localparam logic [63:0] Q31    = 64'd1 << 31;
	localparam logic [63:0] A_STEP = (64'd1 << 35) / DEPTH;

	typedef logic [TAB_W-1:0] rom_t [DEPTH+1];

	// Restoring division, used only while the table is built.
	function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Entry k is tanh(8k/DEPTH) in Q.16, from powers of exp(-16/DEPTH).
	function automatic rom_t build_rom();
		logic [63:0] term;
		logic [63:0] e;
		logic [63:0] p;
		logic [63:0] num;
		logic [63:0] den;
		logic signed [63:0] sum;
		rom_t t;
		term = Q31;
		sum  = signed'(Q31);
		for (int n = 1; n <= 12; n++) begin
			term = udiv((term * A_STEP) >> 31, 64'(n));
			if (n % 2 == 1)
				sum = sum - signed'(term);
			else
				sum = sum + signed'(term);
		end
		e = unsigned'(sum);
		p = Q31;
		for (int k = 0; k <= DEPTH; k++) begin
			if (k > 0)
				p = (p * e + (64'd1 << 30)) >> 31;
			if (p > Q31)
				p = Q31;
			num = (Q31 - p) << 16;
			den = Q31 + p;
			t[k] = TAB_W'(udiv(num + (den >> 1), den));
		end
		return t;
	endfunction

	localparam rom_t ROM = build_rom();

	always_ff @(posedge clk) begin
		if (rd_en) begin
			lo <= ROM[addr];
			hi <= ROM[addr + AW'(1)];
		end
	end

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the tanh overdrive sample shaper.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tod_pkg::*;

	localparam int SW         = 16;
	localparam int FRAC       = SW - 1;
	localparam int TANH_DEPTH = 1024;
	localparam int LATENCY    = 7;
	localparam int PHASE_ITEMS = 510;
	localparam longint unsigned Q31 = 64'd1 << 31;
	localparam longint unsigned Q16 = 64'd65536;

	typedef longint unsigned u64_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	tod_in_if  #(.W(SW)) in_ch ();
	tod_out_if #(.W(SW)) out_ch ();

	tanh_overdrive_sample #(
		.TANH_TABLE_DEPTH(TANH_DEPTH),
		.SAMPLE_WIDTH(SW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// Software view of the registers, kept in step with every write.
	logic [MODE_W-1:0]  cfg_mode;
	logic [GAIN_W-1:0]  cfg_gain;
	logic [RECIP_W-1:0] cfg_recip;

	longint unsigned tanh_rom [0:TANH_DEPTH];
	logic [SW-1:0] shaped_q [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Fixed-point tanh table over [0, 8]: exp(-16/D) from a truncated series,
	// then tanh = (1 - p) / (1 + p) with p its running power.
	function automatic void build_tanh_rom();
		longint unsigned a, term, e, p, num, den;
		longint sum;
		a = (64'd1 << 35) / TANH_DEPTH;
		term = Q31;
		sum = longint'(Q31);
		for (int n = 1; n <= 12; n++) begin
			term = ((term * a) >> 31) / u64_t'(n);
			if (n % 2 == 1)
				sum -= longint'(term);
			else
				sum += longint'(term);
		end
		e = u64_t'(sum);
		p = Q31;
		for (int k = 0; k <= TANH_DEPTH; k++) begin
			if (k > 0)
				p = (p * e + (64'd1 << 30)) >> 31;
			if (p > Q31)
				p = Q31;
			num = (Q31 - p) << 16;
			den = Q31 + p;
			tanh_rom[k] = (num + den / 2) / den;
		end
	endfunction

	function automatic logic [SW-1:0] shape_sample(logic [SW-1:0] x);
		logic neg;
		longint unsigned mag, u, s, idx, f, y, y2, q;
		neg = x[SW-1];
		if (cfg_mode >= MODE_BYPASS)
			return x;
		mag = neg ? ((64'd1 << SW) - u64_t'(x)) : u64_t'(x);
		u = mag * u64_t'(cfg_gain);
		if (u >= (64'd1 << (FRAC + 11))) begin
			y = Q16;
		end else begin
			s = u * TANH_DEPTH;
			idx = s >> (FRAC + 11);
			f = (s >> (FRAC - 5)) & 64'hFFFF;
			y = (tanh_rom[idx] * (Q16 - f) + tanh_rom[idx + 1] * f) >> 16;
		end
		if (cfg_mode == MODE_CUBE) begin
			y2 = (y * y + 64'd32768) >> 16;
			y = (y2 * y + 64'd32768) >> 16;
		end
		q = (y * u64_t'(cfg_recip) + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
		if (neg) begin
			if (q > (64'd1 << FRAC))
				q = 64'd1 << FRAC;
			return SW'(-q);
		end
		if (q > (64'd1 << FRAC) - 1)
			q = (64'd1 << FRAC) - 1;
		return SW'(q);
	endfunction

	// All APB and stream tasks start and end just after a falling edge.
	task automatic apb_write(logic [1:0] idx, logic [APB_DW-1:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = APB_AW'(idx * 4);
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MODE:  cfg_mode = value[MODE_W-1:0];
			REG_GAIN:  cfg_gain = value[GAIN_W-1:0];
			REG_RECIP: cfg_recip = value[RECIP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic apb_check(logic [1:0] idx, logic [APB_DW-1:0] want);
		logic [APB_DW-1:0] got;
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = APB_AW'(idx * 4);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (got !== want) begin
			$error("register %0d: expected %0d, got %0d", idx, want, got);
			mismatches++;
		end
	endtask

	task automatic set_config(logic [MODE_W-1:0] mode, logic [GAIN_W-1:0] gain,
			logic [RECIP_W-1:0] recip);
		apb_write(REG_MODE, APB_DW'(mode));
		apb_write(REG_GAIN, APB_DW'(gain));
		apb_write(REG_RECIP, APB_DW'(recip));
	endtask

	task automatic push_sample(logic [SW-1:0] x);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.sample_in = x;
		do @(posedge clk); while (!in_ch.ready);
		shaped_q.push_back(shape_sample(x));
		@(negedge clk);
	endtask

	// Registers may only change once the pipeline has emptied.
	task automatic wait_drained();
		in_ch.valid = 1'b0;
		while (shaped_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		out_ch.ready = arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (shaped_q.size() == 0) begin
				$error("sample_out: no item expected, got %0d", $signed(out_ch.sample_out));
				mismatches++;
			end else begin
				if (out_ch.sample_out !== shaped_q[0]) begin
					$error("sample_out: expected %0d, got %0d",
						$signed(shaped_q[0]), $signed(out_ch.sample_out));
					mismatches++;
				end
				void'(shaped_q.pop_front());
			end
		end
	end

	task automatic test_register_access();
		apb_check(REG_MODE, APB_DW'(MODE_TANH));
		apb_check(REG_GAIN, APB_DW'(GAIN_RESET));
		apb_check(REG_RECIP, APB_DW'(RECIP_RESET));
		set_config(2'd3, 22'h3FFFFF, 17'h1FFFF);
		apb_check(REG_MODE, 32'd3);
		apb_check(REG_GAIN, 32'h3FFFFF);
		apb_check(REG_RECIP, 32'h1FFFF);
		set_config(MODE_TANH, GAIN_RESET, RECIP_RESET);
	endtask

	task automatic test_directed();
		// Reset settings: unity gain and unity reciprocal.
		push_sample(16'sd0);
		push_sample(16'sd32767);
		push_sample(-16'sd32768);
		push_sample(16'sd1);
		push_sample(-16'sd1);
		push_sample(16'sd16384);
		wait_drained();
		apb_write(REG_MODE, APB_DW'(MODE_CUBE));
		push_sample(16'sd32767);
		push_sample(-16'sd32768);
		push_sample(-16'sd12345);
		wait_drained();
		apb_write(REG_MODE, APB_DW'(MODE_BYPASS));
		push_sample(16'sd32767);
		push_sample(-16'sd32768);
		wait_drained();
		apb_write(REG_MODE, 32'd3);
		push_sample(16'sd21845);
		push_sample(-16'sd21846);
		wait_drained();
		// Largest gain with the smallest nonzero reciprocal.
		set_config(MODE_TANH, 22'h3FFFFF, 17'd1);
		push_sample(16'sd1);
		push_sample(-16'sd1);
		push_sample(16'sd32767);
		wait_drained();
		// Zero gain, then zero reciprocal: both must give silence.
		set_config(MODE_TANH, 22'd0, RECIP_RESET);
		push_sample(16'sd20000);
		wait_drained();
		set_config(MODE_TANH, 22'd1024, 17'd0);
		push_sample(-16'sd20000);
		wait_drained();
		// Gain below unity is used as written.
		set_config(MODE_TANH, 22'd128, RECIP_RESET);
		push_sample(16'sd30000);
		push_sample(-16'sd30000);
		wait_drained();
		// An oversized reciprocal pushes the result past full scale.
		set_config(MODE_TANH, GAIN_RESET, 17'h1FFFF);
		push_sample(16'sd32767);
		push_sample(-16'sd32768);
		wait_drained();
	endtask

	function automatic logic [SW-1:0] pick_sample();
		int unsigned reach;
		logic [SW-1:0] v;
		// Most items sit where g*x is still on the curved part of tanh.
		reach = (cfg_gain == 0) ? 32768 : ((32'd1 << 26) / cfg_gain) + 1;
		if (reach > 32768)
			reach = 32768;
		case ($urandom_range(7))
			0, 1: v = SW'($urandom);
			2: begin
				case ($urandom_range(3))
					0: v = 16'h7FFF;
					1: v = 16'h8000;
					2: v = 16'h0000;
					default: v = 16'hFFFF;
				endcase
			end
			default: begin
				v = SW'($urandom_range(reach));
				if ($urandom_range(1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	task automatic pick_config();
		logic [MODE_W-1:0] mode;
		logic [GAIN_W-1:0] gain;
		logic [RECIP_W-1:0] recip;
		case ($urandom_range(9))
			0, 1, 2, 3: mode = MODE_TANH;
			4, 5, 6, 7: mode = MODE_CUBE;
			8: mode = MODE_BYPASS;
			default: mode = 2'd3;
		endcase
		case ($urandom_range(9))
			0: gain = GAIN_RESET;
			1: gain = 22'h3FFFFF;
			2: gain = GAIN_W'($urandom);
			3: gain = GAIN_W'($urandom_range(255));
			4: gain = GAIN_W'($urandom_range(65536, 256));
			default: gain = GAIN_W'($urandom_range(4096, 256));
		endcase
		case ($urandom_range(9))
			0: recip = RECIP_W'($urandom);
			1: recip = 17'd0;
			2: recip = 17'd1;
			3: recip = RECIP_RESET;
			default: begin
				if (gain == 0)
					recip = RECIP_RESET;
				else if ((32'd1 << 24) / gain > 32'h1FFFF)
					recip = 17'h1FFFF;
				else
					recip = RECIP_W'(((32'd1 << 24) + gain / 2) / gain);
			end
		endcase
		set_config(mode, gain, recip);
	endtask

	task automatic test_random_traffic(int idle_pct, int stall_pct);
		int left;
		int burst;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		left = PHASE_ITEMS;
		while (left > 0) begin
			wait_drained();
			pick_config();
			burst = $urandom_range(70, 30);
			if (burst > left)
				burst = left;
			repeat (burst) push_sample(pick_sample());
			left -= burst;
		end
		wait_drained();
	endtask

	initial begin
		build_tanh_rom();
		cfg_mode = MODE_TANH;
		cfg_gain = GAIN_RESET;
		cfg_recip = RECIP_RESET;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.sample_in = '0;
		out_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_register_access();
		test_directed();
		test_random_traffic(10, 55);
		test_random_traffic(55, 10);
		test_random_traffic(0, 0);

		wait_drained();
		repeat (2 * LATENCY) @(posedge clk);
		if (shaped_q.size() != 0) begin
			$error("sample_out: %0d items never arrived", shaped_q.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("[tanh_overdrive_sample] OK");
		else
			$display("[tanh_overdrive_sample] ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[tanh_overdrive_sample] ERROR");
		$finish;
	end

endmodule
